// ===== rtl/lfd_pkg.sv =====
`default_nettype none

package lfd_pkg;

   // Header geometry: little-endian length, low 32 bits kept
   localparam int HEADER_BYTES = 4;
   localparam int LEN_W        = 32;
   localparam int LEN_BYTES    = (HEADER_BYTES < LEN_W / 8) ? HEADER_BYTES : LEN_W / 8;
   localparam int HDR_IDX_W    = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

   // Command queue between the parser and the result stage
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   typedef enum logic {
      ST_HEADER  = 1'b0,
      ST_PAYLOAD = 1'b1
   } front_state_type;

   typedef enum logic {
      CMD_PAYLOAD = 1'b0,
      CMD_EMPTY   = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         last;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/lfd_front.sv =====
`default_nettype none

module lfd_front
   import lfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire logic [7:0] in_byte,
   output cmd_type         cmd,
   output logic            cmd_valid
);

   front_state_type          state_ff, state_in;
   logic [HDR_IDX_W-1:0]     hdr_idx_ff, hdr_idx_in;
   logic [LEN_W-1:0]         accum_ff, accum_in;
   logic [LEN_W-1:0]         left_ff, left_in;
   logic [LEN_W-1:0]         new_len;
   logic                     hdr_last;

   // Merge the incoming header byte into its lane of the length
   always_comb begin
      new_len = accum_ff;
      for (int k = 0; k < LEN_BYTES; k++) begin
         if (hdr_idx_ff == HDR_IDX_W'(k)) begin
            new_len[8*k +: 8] = accum_ff[8*k +: 8] | in_byte;
         end
      end
   end

   assign hdr_last = (hdr_idx_ff == HDR_IDX_W'(HEADER_BYTES - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      if (in_valid) begin
         case (state_ff)
            ST_HEADER: begin
               if (hdr_last && (new_len != '0)) begin
                  state_in = ST_PAYLOAD;
               end
            end
            ST_PAYLOAD: begin
               if (left_ff == LEN_W'(1)) begin
                  state_in = ST_HEADER;
               end
            end
            default: state_in = ST_HEADER;
         endcase
      end
   end

   // Counters, length assembly and command output
   always_comb begin
      hdr_idx_in = hdr_idx_ff;
      accum_in   = accum_ff;
      left_in    = left_ff;
      cmd_valid  = 1'b0;
      cmd.kind   = CMD_PAYLOAD;
      cmd.data   = in_byte;
      cmd.last   = 1'b0;
      if (in_valid) begin
         case (state_ff)
            ST_HEADER: begin
               if (hdr_last) begin
                  hdr_idx_in = '0;
                  accum_in   = '0;
                  if (new_len == '0) begin
                     cmd_valid = 1'b1;
                     cmd.kind  = CMD_EMPTY;
                     cmd.data  = 8'h00;
                     cmd.last  = 1'b1;
                  end else begin
                     left_in = new_len;
                  end
               end else begin
                  hdr_idx_in = hdr_idx_ff + HDR_IDX_W'(1);
                  accum_in   = new_len;
               end
            end
            ST_PAYLOAD: begin
               left_in   = left_ff - LEN_W'(1);
               cmd_valid = 1'b1;
               cmd.last  = (left_ff == LEN_W'(1));
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_HEADER;
         hdr_idx_ff <= '0;
         accum_ff   <= '0;
         left_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         hdr_idx_ff <= hdr_idx_in;
         accum_ff   <= accum_in;
         left_ff    <= left_in;
      end
   end

   a_payload_has_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAYLOAD) |-> (left_ff != '0))
      else $error("payload state with no bytes left");

   a_header_no_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HEADER) |-> (left_ff == '0))
      else $error("byte count left over in header state");

   a_last_leaves_payload: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd.last) |=> (state_ff == ST_HEADER && hdr_idx_ff == '0))
      else $error("frame end did not return to header collection");

endmodule

`default_nettype wire

// ===== rtl/lfd_cmdq.sv =====
`default_nettype none

module lfd_cmdq
   import lfd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output logic         not_empty
);

   cmd_type                 slots_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CMDQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + CMDQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CMDQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CMDQ_CNT_W'(CMDQ_DEPTH))
      else $error("command queue overfilled");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != CMDQ_CNT_W'(CMDQ_DEPTH)) |->
      (CMDQ_PTR_W'(wr_ptr_ff - rd_ptr_ff) == CMDQ_PTR_W'(count_ff)))
      else $error("queue pointers disagree with occupancy");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into full queue");

endmodule

`default_nettype wire

// ===== rtl/lfd_back.sv =====
`default_nettype none

module lfd_back
   import lfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    head_cmd,
   input  wire logic       head_valid,
   output logic            head_take,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_frame_end,
   output logic            rsp_empty_frame
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       end_ff;
   logic       empty_fr_ff;
   logic       drain;

   assign drain     = rsp_pop && valid_ff;
   assign head_take = head_valid && (!valid_ff || drain);

   // Refill the output register whenever it frees up
   always_comb begin
      valid_in = valid_ff;
      if (head_take) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Expand the command into result fields
   always_ff @(posedge clock) begin
      if (head_take) begin
         data_ff     <= (head_cmd.kind == CMD_EMPTY) ? 8'h00 : head_cmd.data;
         end_ff      <= head_cmd.last;
         empty_fr_ff <= (head_cmd.kind == CMD_EMPTY);
      end
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_payload_byte = data_ff;
   assign rsp_frame_end    = end_ff;
   assign rsp_empty_frame  = empty_fr_ff;

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      head_take |=> valid_ff)
      else $error("taken command did not reach output");

   a_empty_frame_ends: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && empty_fr_ff) |-> (end_ff && data_ff == 8'h00))
      else $error("empty frame result malformed");

   a_hold_until_pop: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_pop) |=>
      (valid_ff && $stable(data_ff) && $stable(end_ff) && $stable(empty_fr_ff)))
      else $error("waiting response changed before it was popped");

endmodule

`default_nettype wire

// ===== rtl/length_prefix_deframer.sv =====
`default_nettype none

// Channel   Ports                                          Handshake
// -------   --------------------------------------------   ------------------------------
// request   req_in_byte                                    req_push & !req_full
// response  rsp_payload_byte, rsp_frame_end,               rsp_pop & !rsp_empty
//           rsp_empty_frame
//
// One byte per clock is accepted while req_full is low. Header bytes produce no
// response, except one empty-frame response per zero-length header. A response goes
// parser -> 4-entry command queue -> output register. req_full follows the command
// queue occupancy. Synchronous active-high reset returns to header collection, queue
// empty. A stalled response side fills the queue, then holds off requests.

module length_prefix_deframer
   import lfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   input  wire logic [7:0] req_in_byte,
   output logic            req_full,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_frame_end,
   output logic            rsp_empty_frame
);

   cmd_type front_cmd;
   logic    front_valid;
   cmd_type head_cmd;
   logic    head_valid;
   logic    head_take;
   logic    accept;

   assign accept = req_push && !req_full;

   lfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_byte   (req_in_byte),
      .cmd       (front_cmd),
      .cmd_valid (front_valid)
   );

   lfd_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_cmd  (front_cmd),
      .full      (req_full),
      .pop       (head_take),
      .head_cmd  (head_cmd),
      .not_empty (head_valid)
   );

   lfd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_cmd         (head_cmd),
      .head_valid       (head_valid),
      .head_take        (head_take),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_empty_frame  (rsp_empty_frame)
   );

endmodule

`default_nettype wire

// ===== test/length_prefix_deframer_test.sv =====
`default_nettype none

module length_prefix_deframer_test;
   import lfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       empty;
   } frame_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_full;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_frame_end;
   logic       rsp_empty_frame;

   // Stream bytes waiting for the driver, and responses the deframer still owes
   logic [7:0]       stream_bytes[$];
   frame_result_type owed_results[$];

   // Shadow of the deframer state
   front_state_type parse_state = ST_HEADER;
   int unsigned     hdr_count = 0;
   logic [31:0]     len_accum = '0;
   logic [31:0]     bytes_left = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;
   int bytes_sent = 0;
   int frames_queued = 0;
   int responses_checked = 0;
   int empty_frames_seen = 0;

   length_prefix_deframer uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_in_byte      (req_in_byte),
      .req_full         (req_full),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_empty_frame  (rsp_empty_frame)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Append one byte to the stream awaiting the driver
   function automatic void queue_byte(logic [7:0] b);
      stream_bytes.insert(stream_bytes.size(), b);
   endfunction

   // Append one expected response
   function automatic void owe_result(frame_result_type r);
      owed_results.insert(owed_results.size(), r);
   endfunction

   // Advance the shadow state by one stream byte, queue any response it causes
   function automatic void deframe_byte(logic [7:0] b);
      frame_result_type r;
      if (parse_state == ST_HEADER) begin
         if (hdr_count < 4)
            len_accum = len_accum | (32'(b) << (8 * hdr_count));
         hdr_count++;
         if (hdr_count == HEADER_BYTES) begin
            hdr_count = 0;
            if (len_accum == 0) begin
               r.data  = 8'h00;
               r.last  = 1'b1;
               r.empty = 1'b1;
               owe_result(r);
            end else begin
               bytes_left  = len_accum;
               len_accum   = '0;
               parse_state = ST_PAYLOAD;
            end
         end
      end else begin
         bytes_left = bytes_left - 1;
         r.data  = b;
         r.last  = (bytes_left == 0);
         r.empty = 1'b0;
         owe_result(r);
         if (bytes_left == 0)
            parse_state = ST_HEADER;
      end
   endfunction

   // Queue a little-endian header for len, then body_len random payload bytes
   task automatic add_frame(int unsigned len, int unsigned body_len);
      logic [7:0] hb;
      for (int i = 0; i < HEADER_BYTES; i++) begin
         hb = (i < 4) ? 8'((len >> (8 * i)) & 32'hFF) : 8'($urandom_range(255));
         queue_byte(hb);
      end
      for (int i = 0; i < body_len; i++)
         queue_byte(8'($urandom_range(255)));
      frames_queued++;
   endtask

   // Pick a frame length, mostly short, sometimes past one header byte
   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10)
         return 0;
      else if (r < 80)
         return $urandom_range(8, 1);
      else if (r < 95)
         return $urandom_range(40, 9);
      else
         return $urandom_range(300, 200);
   endfunction

   // Wait until every queued byte went in and every response came out
   task automatic drain();
      while (stream_bytes.size() != 0 || req_push || owed_results.size() != 0)
         @(posedge clock);
   endtask

   // Driver: record accepted transactions, then present the next byte or idle
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            deframe_byte(req_in_byte);
            bytes_sent++;
         end
         if (!req_push || !req_full) begin
            if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_push    <= 1'b1;
               req_in_byte <= stream_bytes.pop_front();
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted response with the oldest one owed
   always @(posedge clock) begin : monitor
      frame_result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (owed_results.size() == 0) begin
               $error("response with none owed: payload_byte=%0h frame_end=%0b empty_frame=%0b",
                      rsp_payload_byte, rsp_frame_end, rsp_empty_frame);
               mismatches++;
            end else begin
               want = owed_results.pop_front();
               responses_checked++;
               if (want.empty)
                  empty_frames_seen++;
               if (rsp_payload_byte !== want.data) begin
                  $error("payload_byte: expected %0h, got %0h", want.data, rsp_payload_byte);
                  mismatches++;
               end
               if (rsp_frame_end !== want.last) begin
                  $error("frame_end: expected %0b, got %0b", want.last, rsp_frame_end);
                  mismatches++;
               end
               if (rsp_empty_frame !== want.empty) begin
                  $error("empty_frame: expected %0b, got %0b", want.empty, rsp_empty_frame);
                  mismatches++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      int phase_bytes;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Phase 1: slow receiver; directed frames first
      send_idle_pct = 29;
      recv_idle_pct = 86;
      add_frame(0, 0);
      add_frame(1, 0);
      queue_byte(8'hFF);
      add_frame(3, 0);
      queue_byte(8'h00);
      queue_byte(8'h55);
      queue_byte(8'hAA);
      add_frame(0, 0);
      phase_bytes = stream_bytes.size();
      while (phase_bytes < 270) begin
         add_frame(pick_length(), 0);
         phase_bytes = stream_bytes.size();
      end
      // add_frame queued only headers for random lengths above; rebuild with bodies
      stream_bytes.delete();
      frames_queued = 0;
      add_frame(0, 0);
      add_frame(1, 0);
      queue_byte(8'hFF);
      add_frame(3, 0);
      queue_byte(8'h00);
      queue_byte(8'h55);
      queue_byte(8'hAA);
      add_frame(0, 0);
      while (stream_bytes.size() < 270) begin
         phase_bytes = pick_length();
         add_frame(phase_bytes, phase_bytes);
      end
      drain();

      // Phase 2: slow sender
      send_idle_pct = 86;
      recv_idle_pct = 29;
      while (stream_bytes.size() < 270) begin
         phase_bytes = pick_length();
         add_frame(phase_bytes, phase_bytes);
      end
      drain();

      // Phase 3: full rate, ending on a maximum-length frame whose payload never completes
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (stream_bytes.size() < 260) begin
         phase_bytes = pick_length();
         add_frame(phase_bytes, phase_bytes);
      end
      add_frame(32'hFFFF_FFFF, 6);
      drain();

      // Let the monitor run on to catch stray responses, then check none are still owed
      repeat (8) @(posedge clock);
      if (owed_results.size() != 0) begin
         $error("%0d responses never arrived", owed_results.size());
         mismatches++;
      end

      $display("Sent %0d stream bytes in %0d frames across three flow-control phases;",
               bytes_sent, frames_queued);
      $display("checked %0d responses, %0d of them empty frames.",
               responses_checked, empty_frames_seen);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog: end a run that never finishes as failed
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/lfd_pkg.sv
rtl/lfd_front.sv
rtl/lfd_cmdq.sv
rtl/lfd_back.sv
rtl/length_prefix_deframer.sv
test/length_prefix_deframer_test.sv
